// ===== src/dhp_pkg.sv =====
// Shared types, constants and helper functions of the dual haptic pattern player.
`timescale 1ns / 1ps

package dhp_pkg;

  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned PROD_W  = 23;
  localparam int unsigned SLOTS   = 4;
  localparam int unsigned SLOT_CW = $clog2(SLOTS + 1);

  localparam logic [DUTY_W-1:0]  DUTY_MAX        = 7'd100;
  localparam logic [TIME_W-1:0]  OFF_MIN         = 16'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_ON_RESET  = 8'h10;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF_RESET = 8'h00;
  localparam logic [PROD_W-1:0]  ON_PROD_RESET   = 23'd2000;
  localparam logic [PROD_W-1:0]  OFF_PROD_RESET  = 23'd20000;
  localparam logic [PROD_W-1:0]  ROUND_UP        = 23'd99;

  typedef enum logic [1:0] {
    REG_M1_ON  = 2'd0,
    REG_M1_OFF = 2'd1,
    REG_M2_ON  = 2'd2,
    REG_M2_OFF = 2'd3
  } cfg_reg_t;

  // Phase durations are kept as percent products: on = floor(on_prod / 100) and
  // off = max(ceil(off_prod / 100), 5), so no divider is needed.
  typedef struct packed {
    logic [TIME_W-1:0] count;
    logic              phase;
    logic [PROD_W-1:0] on_prod;
    logic [PROD_W-1:0] off_prod;
    logic              active;
  } mot_t;

  typedef struct packed {
    logic              upd;
    logic              zero;
    logic [PROD_W-1:0] on_prod;
    logic [PROD_W-1:0] off_prod;
  } upd_t;

  typedef struct packed {
    logic               which_motor;
    logic [LEVEL_W-1:0] drive_level;
    logic               last;
  } wr_t;

  function automatic logic [PROD_W-1:0] times100(input logic [TIME_W-1:0] c);
    return PROD_W'({c, 6'b0}) + PROD_W'({c, 5'b0}) + PROD_W'({c, 2'b0});
  endfunction

  function automatic mot_t mot_advance(input mot_t m);
    logic [TIME_W-1:0] c1;
    logic [PROD_W-1:0] c100;
    logic              done;
    mot_t              r;
    c1   = m.count + 16'd1;
    c100 = times100(c1);
    if (m.phase) begin
      done = (c1 >= OFF_MIN) && (c100 >= m.off_prod);
    end else begin
      done = (c100 + ROUND_UP) >= m.on_prod;
    end
    r       = m;
    r.count = done ? '0 : c1;
    r.phase = done ? ~m.phase : m.phase;
    return r;
  endfunction

  function automatic mot_t mot_apply(input mot_t m, input upd_t u);
    mot_t r;
    r = m;
    if (u.upd) begin
      if (u.zero) begin
        r.active = 1'b0;
      end else begin
        r.count    = '0;
        r.phase    = 1'b0;
        r.on_prod  = u.on_prod;
        r.off_prod = u.off_prod;
        r.active   = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/dhp_ifs.sv =====
// Request channel interfaces for the tick input and the level write output.
`timescale 1ns / 1ps

interface dhp_tick_if;
  import dhp_pkg::*;
  logic                valid;
  logic                ready;
  logic                m1_update;
  logic [DUTY_W-1:0]   m1_duty;
  logic                m2_update;
  logic [DUTY_W-1:0]   m2_duty;
  logic [TIME_W-1:0]   period_ms;

  modport source (output valid, m1_update, m1_duty, m2_update, m2_duty, period_ms,
                  input ready);
  modport sink (input valid, m1_update, m1_duty, m2_update, m2_duty, period_ms,
                output ready);
endinterface

interface dhp_wr_if;
  import dhp_pkg::*;
  logic               valid;
  logic               ready;
  logic               which_motor;
  logic [LEVEL_W-1:0] drive_level;
  logic               last;

  modport source (output valid, which_motor, drive_level, last, input ready);
  modport sink (input valid, which_motor, drive_level, last, output ready);
endinterface

// ===== src/dual_haptic_duty_pattern_player.sv =====
// Top level of the dual haptic duty pattern player.
`timescale 1ns / 1ps

// Each tick request may carry a duty update per motor and produces zero to four
// level write requests, emitted one per cycle while the sink is ready, in order,
// with the final one flagged by last. The on and off products are formed in the
// input register stage, and the motor state update and the write list are built
// from that register into a four-entry write buffer once the buffer is free; the
// first write is then presented from the buffer head. The input register can take
// a new tick while the buffer still drains, but that tick waits there until the
// buffer is empty or its final write is being taken, so ticks that cause several
// writes hold back the ticks behind them, set by the single output port of the write buffer.
module dual_haptic_duty_pattern_player (
  input  logic                    clk,
  input  logic                    rst_n,
  dhp_tick_if.sink                in_tick,
  dhp_wr_if.source                out_wr,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_addr,
  input  logic [dhp_pkg::LEVEL_W-1:0] cfg_wdata
);
  import dhp_pkg::*;

  logic [LEVEL_W-1:0] m1_on_lvl_r, m1_off_lvl_r, m2_on_lvl_r, m2_off_lvl_r;

  logic              s1_valid_r;
  upd_t              s1_u1_r, s1_u2_r;
  upd_t              u1_nxt, u2_nxt;
  logic [DUTY_W-1:0] d1_sat, d2_sat;

  mot_t m1_r, m2_r, m1_nxt, m2_nxt, m1_up, m2_up;
  logic adv;

  wr_t                ent_r [SLOTS];
  wr_t                ent_nxt [SLOTS];
  logic [SLOT_CW-1:0] rem_r;
  logic [SLOT_CW-1:0] n_nxt;
  logic               buf_free, load, out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_on_lvl_r  <= LEVEL_ON_RESET;
      m1_off_lvl_r <= LEVEL_OFF_RESET;
      m2_on_lvl_r  <= LEVEL_ON_RESET;
      m2_off_lvl_r <= LEVEL_OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_M1_ON:  m1_on_lvl_r  <= cfg_wdata;
        REG_M1_OFF: m1_off_lvl_r <= cfg_wdata;
        REG_M2_ON:  m2_on_lvl_r  <= cfg_wdata;
        REG_M2_OFF: m2_off_lvl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_take = out_wr.valid && out_wr.ready;
  assign buf_free = (rem_r == '0) || ((rem_r == SLOT_CW'(1)) && out_wr.ready);
  assign load     = s1_valid_r && buf_free;
  assign in_tick.ready = !s1_valid_r || buf_free;

  always_comb begin
    d1_sat = (in_tick.m1_duty > DUTY_MAX) ? DUTY_MAX : in_tick.m1_duty;
    d2_sat = (in_tick.m2_duty > DUTY_MAX) ? DUTY_MAX : in_tick.m2_duty;
    u1_nxt.upd      = in_tick.m1_update;
    u1_nxt.zero     = (d1_sat == '0);
    u1_nxt.on_prod  = PROD_W'(in_tick.period_ms) * PROD_W'(d1_sat);
    u1_nxt.off_prod = PROD_W'(in_tick.period_ms) * PROD_W'(DUTY_MAX - d1_sat);
    u2_nxt.upd      = in_tick.m2_update;
    u2_nxt.zero     = (d2_sat == '0);
    u2_nxt.on_prod  = PROD_W'(in_tick.period_ms) * PROD_W'(d2_sat);
    u2_nxt.off_prod = PROD_W'(in_tick.period_ms) * PROD_W'(DUTY_MAX - d2_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tick.valid && in_tick.ready) begin
      s1_valid_r <= 1'b1;
    end else if (load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tick.valid && in_tick.ready) begin
      s1_u1_r <= u1_nxt;
      s1_u2_r <= u2_nxt;
    end
  end

  always_comb begin
    m1_up  = mot_apply(m1_r, s1_u1_r);
    m2_up  = mot_apply(m2_r, s1_u2_r);
    adv    = m1_up.active && m2_up.active;
    m1_nxt = adv ? mot_advance(m1_up) : m1_up;
    m2_nxt = adv ? mot_advance(m2_up) : m2_up;

    for (int i = 0; i < SLOTS; i++) begin
      ent_nxt[i] = '0;
    end
    n_nxt = '0;
    if (s1_u1_r.upd) begin
      ent_nxt[n_nxt[1:0]].which_motor = 1'b0;
      ent_nxt[n_nxt[1:0]].drive_level = s1_u1_r.zero ? '0 : m1_on_lvl_r;
      n_nxt = n_nxt + SLOT_CW'(1);
    end
    if (s1_u2_r.upd) begin
      ent_nxt[n_nxt[1:0]].which_motor = 1'b1;
      ent_nxt[n_nxt[1:0]].drive_level = s1_u2_r.zero ? '0 : m2_on_lvl_r;
      n_nxt = n_nxt + SLOT_CW'(1);
    end
    if (adv) begin
      ent_nxt[n_nxt[1:0]].which_motor = 1'b0;
      ent_nxt[n_nxt[1:0]].drive_level = m1_nxt.phase ? m1_off_lvl_r : m1_on_lvl_r;
      n_nxt = n_nxt + SLOT_CW'(1);
      ent_nxt[n_nxt[1:0]].which_motor = 1'b1;
      ent_nxt[n_nxt[1:0]].drive_level = m2_nxt.phase ? m2_off_lvl_r : m2_on_lvl_r;
      n_nxt = n_nxt + SLOT_CW'(1);
    end
    for (int i = 0; i < SLOTS; i++) begin
      ent_nxt[i].last = ((SLOT_CW'(i) + SLOT_CW'(1)) == n_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '{count: '0, phase: 1'b0, on_prod: ON_PROD_RESET,
                off_prod: OFF_PROD_RESET, active: 1'b0};
      m2_r <= '{count: '0, phase: 1'b0, on_prod: ON_PROD_RESET,
                off_prod: OFF_PROD_RESET, active: 1'b0};
    end else if (load) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= n_nxt;
    end else if (out_take) begin
      rem_r <= rem_r - SLOT_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= ent_nxt;
    end else if (out_take) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

  assign out_wr.valid       = (rem_r != '0);
  assign out_wr.which_motor = ent_r[0].which_motor;
  assign out_wr.drive_level = ent_r[0].drive_level;
  assign out_wr.last        = ent_r[0].last;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= SLOT_CW'(SLOTS))
    else $error("write buffer count exceeds its depth");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr.valid |-> (out_wr.last == (rem_r == SLOT_CW'(1))))
    else $error("last flag does not match the final buffered write");

  a_stall_has_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tick.ready |-> s1_valid_r && (rem_r != '0))
    else $error("input stalled without a pending tick and busy buffer");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && (rem_r > SLOT_CW'(1)) |=> out_wr.valid)
    else $error("write buffer lost entries while draining");

  a_advance_pair: assert property (@(posedge clk) disable iff (!rst_n)
    load && adv |=> (rem_r >= SLOT_CW'(2)))
    else $error("counted tick did not queue both motor writes");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the dual haptic duty pattern player with a motor predictor.
`timescale 1ns / 1ps

module tb_top;
  import dhp_pkg::*;

  localparam logic MOTOR_ONE = 1'b0;
  localparam logic MOTOR_TWO = 1'b1;
  localparam logic [TIME_W-1:0] ON_DUR_RESET  = 16'd20;
  localparam logic [TIME_W-1:0] OFF_DUR_RESET = 16'd200;
  localparam int RANDOM_TICKS_PER_PHASE = 50;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic              m1_update;
    logic [DUTY_W-1:0] m1_duty;
    logic              m2_update;
    logic [DUTY_W-1:0] m2_duty;
    logic [TIME_W-1:0] period_ms;
  } tick_t;

  typedef struct {
    logic [TIME_W-1:0]  count;
    logic               phase;
    logic [TIME_W-1:0]  on_dur;
    logic [TIME_W-1:0]  off_dur;
    logic               active;
    logic [LEVEL_W-1:0] on_level;
    logic [LEVEL_W-1:0] off_level;
  } motor_state_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [LEVEL_W-1:0] cfg_wdata;

  dhp_tick_if tick_bus ();
  dhp_wr_if   wr_bus ();

  dual_haptic_duty_pattern_player dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tick  (tick_bus),
    .out_wr   (wr_bus),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  tick_t        ticks_pending[$];
  tick_t        tick_on_bus;
  wr_t          level_writes_due[$];
  motor_state_t motors[2];

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int mismatches      = 0;
  int ticks_accepted  = 0;
  int writes_checked  = 0;
  int phase_flips     = 0;
  int saturated_duties = 0;
  int drain_pauses    = 0;

  function automatic tick_t make_tick(logic u1, logic [DUTY_W-1:0] d1, logic u2,
                                      logic [DUTY_W-1:0] d2, logic [TIME_W-1:0] period);
    tick_t t;
    t.m1_update = u1;
    t.m1_duty   = d1;
    t.m2_update = u2;
    t.m2_duty   = d2;
    t.period_ms = period;
    return t;
  endfunction

  function automatic logic [DUTY_W-1:0] random_duty();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 14) return DUTY_W'($urandom_range(127, 101));
    return DUTY_W'($urandom_range(100, 1));
  endfunction

  function automatic wr_t level_write(logic which, logic [LEVEL_W-1:0] level);
    wr_t w;
    w.which_motor = which;
    w.drive_level = level;
    w.last        = 1'b0;
    return w;
  endfunction

  function automatic logic [LEVEL_W-1:0] current_level(int m);
    return motors[m].phase ? motors[m].off_level : motors[m].on_level;
  endfunction

  function automatic logic [LEVEL_W-1:0] apply_duty(int m, logic [DUTY_W-1:0] duty_in,
                                                    logic [TIME_W-1:0] period);
    int unsigned duty;
    int unsigned on_t;
    int unsigned off_t;
    duty = 32'(duty_in);
    if (duty > 32'(DUTY_MAX)) begin
      duty = 32'(DUTY_MAX);
      saturated_duties++;
    end
    if (duty == 0) begin
      motors[m].active = 1'b0;
      return '0;
    end
    on_t  = 32'(period) * duty / 100;
    off_t = 32'(period) - on_t;
    if (off_t < 32'(OFF_MIN)) off_t = 32'(OFF_MIN);
    motors[m].on_dur   = TIME_W'(on_t);
    motors[m].off_dur  = TIME_W'(off_t);
    motors[m].phase    = 1'b0;
    motors[m].count    = '0;
    motors[m].active   = 1'b1;
    return current_level(m);
  endfunction

  function automatic void advance_motor(int m);
    logic [TIME_W-1:0] dur;
    motors[m].count = motors[m].count + 16'd1;
    dur = motors[m].phase ? motors[m].off_dur : motors[m].on_dur;
    if (motors[m].count >= dur) begin
      motors[m].count = '0;
      motors[m].phase = ~motors[m].phase;
      phase_flips++;
    end
  endfunction

  function automatic void predict_tick(tick_t t);
    wr_t batch[$];
    if (t.m1_update)
      batch.push_back(level_write(MOTOR_ONE, apply_duty(0, t.m1_duty, t.period_ms)));
    if (t.m2_update)
      batch.push_back(level_write(MOTOR_TWO, apply_duty(1, t.m2_duty, t.period_ms)));
    if (motors[0].active && motors[1].active) begin
      advance_motor(0);
      advance_motor(1);
      batch.push_back(level_write(MOTOR_ONE, current_level(0)));
      batch.push_back(level_write(MOTOR_TWO, current_level(1)));
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) level_writes_due.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_bus.valid     <= 1'b0;
      tick_bus.m1_update <= 1'b0;
      tick_bus.m1_duty   <= '0;
      tick_bus.m2_update <= 1'b0;
      tick_bus.m2_duty   <= '0;
      tick_bus.period_ms <= '0;
    end else begin
      if (tick_bus.valid && tick_bus.ready) begin
        predict_tick(tick_on_bus);
        ticks_accepted++;
      end
      if (!tick_bus.valid || tick_bus.ready) begin
        if (ticks_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          tick_on_bus = ticks_pending.pop_front();
          tick_bus.valid     <= 1'b1;
          tick_bus.m1_update <= tick_on_bus.m1_update;
          tick_bus.m1_duty   <= tick_on_bus.m1_duty;
          tick_bus.m2_update <= tick_on_bus.m2_update;
          tick_bus.m2_duty   <= tick_on_bus.m2_duty;
          tick_bus.period_ms <= tick_on_bus.period_ms;
        end else begin
          tick_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    wr_t want;
    if (!rst_n) begin
      wr_bus.ready <= 1'b0;
    end else begin
      if (wr_bus.valid && wr_bus.ready) begin
        writes_checked++;
        if (level_writes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected level write: motor %0d level %0d last %0d",
                     wr_bus.which_motor, wr_bus.drive_level, wr_bus.last);
        end else begin
          want = level_writes_due.pop_front();
          if (wr_bus.which_motor !== want.which_motor ||
              wr_bus.drive_level !== want.drive_level ||
              wr_bus.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"level write mismatch at %0t: expected motor %0d level %0d ",
                        "last %0d, got motor %0d level %0d last %0d"},
                       $realtime, want.which_motor, want.drive_level, want.last,
                       wr_bus.which_motor, wr_bus.drive_level, wr_bus.last);
          end
        end
      end
      wr_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic write_level(cfg_reg_t idx, logic [LEVEL_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_M1_ON:  motors[0].on_level  = value;
      REG_M1_OFF: motors[0].off_level = value;
      REG_M2_ON:  motors[1].on_level  = value;
      REG_M2_OFF: motors[1].off_level = value;
      default: ;
    endcase
  endtask

  task automatic set_levels(logic [LEVEL_W-1:0] m1_on, logic [LEVEL_W-1:0] m1_off,
                            logic [LEVEL_W-1:0] m2_on, logic [LEVEL_W-1:0] m2_off);
    write_level(REG_M1_ON, m1_on);
    write_level(REG_M1_OFF, m1_off);
    write_level(REG_M2_ON, m2_on);
    write_level(REG_M2_OFF, m2_off);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The block may still be working on a tick that causes no write, so the task
  // keeps waiting after the last expected write before anything else happens.
  task automatic wait_until_drained();
    @(posedge clk);
    while (ticks_pending.size() != 0 || tick_bus.valid || level_writes_due.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
    drain_pauses++;
  endtask

  initial begin
    int roll;
    logic [TIME_W-1:0] period;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_addr           = REG_M1_ON;
    cfg_wdata          = '0;
    for (int m = 0; m < 2; m++) begin
      motors[m].count     = '0;
      motors[m].phase     = 1'b0;
      motors[m].on_dur    = ON_DUR_RESET;
      motors[m].off_dur   = OFF_DUR_RESET;
      motors[m].active    = 1'b0;
      motors[m].on_level  = LEVEL_ON_RESET;
      motors[m].off_level = LEVEL_OFF_RESET;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b0, 7'd0, 16'd0));
    ticks_pending.push_back(make_tick(1'b0, 7'd127, 1'b0, 7'd127, 16'hFFFF));
    ticks_pending.push_back(make_tick(1'b1, 7'd50, 1'b0, 7'd0, 16'd4));
    ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b0, 7'd0, 16'd0));
    ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b1, 7'd0, 16'd7));
    ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b1, 7'd127, 16'd10));
    repeat (4) ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b0, 7'd0, 16'd0));
    ticks_pending.push_back(make_tick(1'b1, 7'd1, 1'b0, 7'd0, 16'd50));
    repeat (2) ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b0, 7'd0, 16'd0));
    ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b1, 7'd30, 16'd0));
    repeat (2) ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b0, 7'd0, 16'd0));
    ticks_pending.push_back(make_tick(1'b1, 7'd100, 1'b1, 7'd99, 16'hFFFF));
    repeat (2) ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b0, 7'd0, 16'd0));
    ticks_pending.push_back(make_tick(1'b1, 7'd0, 1'b1, 7'd100, 16'hFFFF));
    ticks_pending.push_back(make_tick(1'b1, 7'd100, 1'b0, 7'd0, 16'd1));
    repeat (3) ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b0, 7'd0, 16'd0));
    ticks_pending.push_back(make_tick(1'b1, 7'd0, 1'b1, 7'd0, 16'd0));
    ticks_pending.push_back(make_tick(1'b0, 7'd0, 1'b0, 7'd0, 16'd0));
    wait_until_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          set_levels(8'hFF, 8'h00, 8'h00, 8'hFF);
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        1: begin
          set_levels(LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                     LEVEL_W'($urandom));
          sender_idle_pct = 62;
          sink_stall_pct  = 0;
        end
        2: begin
          set_levels(8'h00, 8'hFF, 8'hFF, 8'h00);
          sender_idle_pct = 0;
          sink_stall_pct  = 62;
        end
        default: begin
          set_levels(LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                     LEVEL_W'($urandom));
          sender_idle_pct = 22;
          sink_stall_pct  = 22;
        end
      endcase
      // Start each phase with both motors running so that counting happens.
      ticks_pending.push_back(make_tick(1'b1, random_duty() | 7'd1, 1'b1, random_duty() | 7'd1,
                                        TIME_W'($urandom_range(30))));
      for (int i = 0; i < RANDOM_TICKS_PER_PHASE; i++) begin
        roll = $urandom_range(99);
        if (roll < 70) period = TIME_W'($urandom_range(24));
        else if (roll < 90) period = TIME_W'($urandom_range(400, 25));
        else if (roll < 98) period = TIME_W'($urandom);
        else period = 16'hFFFF;
        ticks_pending.push_back(make_tick($urandom_range(99) < 12, random_duty(),
                                          $urandom_range(99) < 12, random_duty(), period));
      end
      wait_until_drained();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d ticks and %0d level writes across five level settings and four",
             ticks_accepted, writes_checked);
    $display("handshake mixes, with %0d phase flips, %0d saturated duties and %0d drained pauses.",
             phase_flips, saturated_duties, drain_pauses);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d level writes still expected.", level_writes_due.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
src/dhp_pkg.sv
src/dhp_ifs.sv
src/dual_haptic_duty_pattern_player.sv
tb/tb_top.sv
